[hdl/xysm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XY spin Metropolis update: shared package
// Lattice constants, payload structs, sequencer states and constant tables.
// ----------------------------------------------------------------------------
package xysm_pkg;

	// lattice geometry (SIDE must be a power of two)
	localparam int SIDE       = 64;
	localparam int ANGLE_BITS = 16;
	localparam int SIDE_BITS  = $clog2(SIDE);
	localparam int ADDR_BITS  = 2 * SIDE_BITS;
	localparam int NSITES     = SIDE * SIDE;
	localparam int ONE_Q14    = 16384;

	// CORDIC datapath
	localparam int CORDIC_ITERS = 16;
	localparam int CW           = 34;

	// configuration register indexes
	localparam logic [1:0] CFG_RATIO = 2'd0;
	localparam logic [1:0] CFG_TEMP  = 2'd1;

	// totals after reset (reset ratio is 410)
	localparam int RATIO_RESET = 410;
	localparam int TEMP_RESET  = 4096;
	localparam logic signed [27:0] COS_RESET = 28'(NSITES * ONE_Q14);
	localparam logic signed [47:0] ENERGY_RESET =
		48'((3 * ONE_Q14 + 24 * RATIO_RESET) * (NSITES / 2));

	// request and result payloads
	typedef struct packed {
		logic        operation;
		logic [5:0]  site_row;
		logic [5:0]  site_col;
		logic [15:0] angle_step;
		logic [15:0] uniform_draw;
	} req_t;

	typedef struct packed {
		logic               accepted;
		logic signed [47:0] total_energy;
		logic signed [27:0] mag_cos_sum;
		logic signed [27:0] mag_sin_sum;
		logic [26:0]        mag_magnitude;
	} res_t;

	// trig unit handshake
	typedef struct packed {
		logic                  start;
		logic [ANGLE_BITS-1:0] phase;
	} cordic_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] cos_val;
		logic signed [15:0] sin_val;
	} cordic_rsp_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RD_CTR,
		ST_LD_CTR,
		ST_RD_NB,
		ST_LD_NB,
		ST_TRIG,
		ST_TWAIT,
		ST_MUL_NEW,
		ST_MUL_OLD,
		ST_DE,
		ST_DECIDE,
		ST_DIV,
		ST_MUL_B,
		ST_POW,
		ST_FIN,
		ST_UPDATE,
		ST_MAG1,
		ST_MAG2,
		ST_SQRT,
		ST_OUT
	} state_t;

	// CORDIC rotation angles, 2^32 per turn
	localparam logic signed [CW-1:0] ROT_TAB [CORDIC_ITERS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
	};

	// integer square root, evaluated at elaboration only
	function automatic logic [63:0] isqrt_c(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		int i;
		n = n_in;
		r = '0;
		b = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(-2^-k) in Q.30 for k >= 1 (entry 0 is one), by repeated square roots from one half
	typedef logic [30:0] pow_tab_t [17];

	function automatic pow_tab_t pow_table();
		pow_tab_t t;
		logic [63:0] p;
		int k;
		p = 64'd1 << 30;
		t[0] = 31'(p);
		p = isqrt_c(64'd1 << 59);
		t[1] = 31'(p);
		for (k = 2; k <= 16; k++) begin
			p = isqrt_c(p << 30);
			t[k] = 31'(p);
		end
		return t;
	endfunction

	localparam pow_tab_t POW_TAB = pow_table();

endpackage

[hdl/xysm_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XY spin Metropolis update: iterative CORDIC
// Cos and sin of a phase in Q.14, one rotation per cycle.
// ----------------------------------------------------------------------------
module xysm_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  xysm_pkg::cordic_req_t creq,
	output xysm_pkg::cordic_rsp_t crsp
);
	import xysm_pkg::*;

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [3:0]           i_q;
	logic                 busy_q, last_q, neg_q, done_q;
	logic signed [15:0]   cos_q, sin_q;

	logic [31:0]          u;
	logic signed [CW-1:0] z0, z_fold, dx, dy, xf, yf;
	logic                 neg0;

	function automatic logic signed [15:0] round_clamp(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = (v + 34'sd32768) >>> 16;
		if (r > 34'sd16384)
			return 16'sd16384;
		else if (r < -34'sd16384)
			return -16'sd16384;
		else
			return 16'(r);
	endfunction

	// phase folding into the right half plane
	always_comb begin
		u  = 32'({creq.phase, 32'b0} >> ANGLE_BITS);
		z0 = CW'(signed'(u));
		neg0 = 1'b0;
		z_fold = z0;
		if (z0 > 34'sd1073741824) begin
			z_fold = z0 - 34'sd2147483648;
			neg0 = 1'b1;
		end else if (z0 < -34'sd1073741824) begin
			z_fold = z0 + 34'sd2147483648;
			neg0 = 1'b1;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		xf = neg_q ? -x_q : x_q;
		yf = neg_q ? -y_q : y_q;
	end

	// rotation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			last_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (creq.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(CORDIC_ITERS - 1)) begin
					busy_q <= 1'b0;
					last_q <= 1'b1;
				end
			end else if (last_q) begin
				last_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// rotation datapath
	always_ff @(posedge clk) begin
		if (creq.start) begin
			x_q   <= 34'sd652032874;
			y_q   <= '0;
			z_q   <= z_fold;
			neg_q <= neg0;
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ROT_TAB[i_q];
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ROT_TAB[i_q];
			end
		end else if (last_q) begin
			cos_q <= round_clamp(xf);
			sin_q <= round_clamp(yf);
		end
	end

	assign crsp.done    = done_q;
	assign crsp.cos_val = cos_q;
	assign crsp.sin_val = sin_q;

endmodule

[hdl/xy_spin_metropolis_update_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XY spin Metropolis update: top level
// Honeycomb XY lattice in one spin memory with a sequencer around it.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel req/req_valid/req_stall carries one operation: a clear or a
//  Metropolis trial at one site. Every request gives exactly one result on
//  rsp/rsp_valid/rsp_stall: acceptance flag, energy and magnetization totals.
//  Configuration writes (cfg_valid/cfg_index/cfg_data, always ready) set the coupling ratio
//  (index 0) and temperature (index 1); the user must write them only while idle (the block does not enforce it).
// Operation:
//  One request at a time. A trial takes ten spin-memory reads, up to twenty
//  runs of the single shared CORDIC unit, a serial divider and the 2^-x
//  product when needed, and a square root. A clear sweeps the spin memory,
//  one memory write per cycle.
// Reset:
//  After reset the block sweeps the spin memory to zero with req_stall high;
//  configuration writes are taken meanwhile.
// Stall:
//  The result sits in an output register. The block takes the next request
//  while the result waits; it holds the following result until the register
//  has been taken.
// ----------------------------------------------------------------------------
module xy_spin_metropolis_update_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  xysm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output xysm_pkg::res_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import xysm_pkg::*;

	// spin memory
	logic [ANGLE_BITS-1:0] spin_mem [NSITES];
	logic [ANGLE_BITS-1:0] mem_rdata;
	logic [ADDR_BITS-1:0]  mem_addr;
	logic [ANGLE_BITS-1:0] mem_wdata;
	logic                  mem_we;

	state_t state_q, state_d;

	// configuration and totals
	logic signed [15:0] ratio_q, temp_q;
	logic signed [27:0] cos_tot_q, sin_tot_q;
	logic signed [47:0] energy_q;

	// request context
	logic [SIDE_BITS-1:0]  row_q, col_q;
	logic [ANGLE_BITS-1:0] step_q, old_q, nw_q, other_q;
	logic [15:0]           draw_q;
	logic                  clr_pend_q, acc_q, pass_q, self_q;
	logic [3:0]            j_q;
	logic [ADDR_BITS-1:0]  sweep_q;

	// energy path
	logic signed [18:0] nn_new_q, nn_old_q, nnn_new_q, nnn_old_q;
	logic signed [34:0] prod_new_q, prod_old_q;
	logic signed [24:0] de_q;
	logic signed [15:0] co_q, so_q, cn_q, sn_q;

	// acceptance path
	logic [36:0] div_dq_q;
	logic [14:0] div_rem_q;
	logic [5:0]  div_cnt_q;
	logic [26:0] b_q;
	logic [30:0] v_q;
	logic [4:0]  k_q;

	// magnitude path
	logic [55:0] sq_c_q, sq_n_q, sq_r_q, sq_bit_q;
	logic [4:0]  sq_cnt_q;

	// output register
	logic rsp_valid_q;
	res_t rsp_q;

	cordic_req_t creq;
	cordic_rsp_t crsp;

	xysm_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.creq   (creq),
		.crsp   (crsp)
	);

	// combinational helpers
	logic                  req_acc, out_free, last_nb;
	logic [SIDE_BITS-1:0]  rp, rm, rp2, rm2, cp, cm, nb_r, nb_c;
	logic [ANGLE_BITS-1:0] base_ph;
	logic signed [24:0]    rnd_new, rnd_old, de_w;
	logic [15:0]           rem_sh;
	logic                  rem_ge;
	logic [61:0]           pow_prod;
	logic [30:0]           v_sh;
	logic [16:0]           p_w;
	logic                  fin_acc;
	logic [55:0]           sq_try;
	logic signed [47:0]    e_clr;
	logic signed [18:0]    cos_ext;

	assign req_acc  = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign last_nb  = (j_q == 4'd8);

	// neighbor addressing on the periodic lattice
	always_comb begin
		rp  = row_q + SIDE_BITS'(1);
		rm  = row_q - SIDE_BITS'(1);
		rp2 = row_q + SIDE_BITS'(2);
		rm2 = row_q - SIDE_BITS'(2);
		cp  = col_q + SIDE_BITS'(1);
		cm  = col_q - SIDE_BITS'(1);
		unique case (j_q)
			4'd0: begin
				nb_r = row_q;
				nb_c = (row_q[0] == col_q[0]) ? cm : cp;
			end
			4'd1: begin nb_r = rp;  nb_c = col_q; end
			4'd2: begin nb_r = rm;  nb_c = col_q; end
			4'd3: begin nb_r = rp;  nb_c = cm;    end
			4'd4: begin nb_r = rp;  nb_c = cp;    end
			4'd5: begin nb_r = rm;  nb_c = cp;    end
			4'd6: begin nb_r = rm;  nb_c = cm;    end
			4'd7: begin nb_r = rp2; nb_c = col_q; end
			4'd8: begin nb_r = rm2; nb_c = col_q; end
			default: begin nb_r = row_q; nb_c = col_q; end
		endcase
	end

	// datapath arithmetic
	always_comb begin
		base_ph = pass_q ? old_q : nw_q;
		cos_ext = 19'(crsp.cos_val);
		rnd_new = 25'((prod_new_q + 35'sd2048) >>> 12);
		rnd_old = 25'((prod_old_q + 35'sd2048) >>> 12);
		de_w    = 25'(nn_new_q) - 25'(nn_old_q) + rnd_new - rnd_old;
		rem_sh  = {div_rem_q, div_dq_q[36]};
		rem_ge  = (rem_sh >= {1'b0, temp_q[14:0]});
		pow_prod = 62'(v_q) * 62'(POW_TAB[k_q]) + (62'd1 << 29);
		v_sh    = v_q >> b_q[20:16];
		p_w     = 17'((32'(v_sh) + 32'd8192) >> 14);
		fin_acc = (b_q[26:16] <= 11'd16) && ({1'b0, draw_q} < p_w);
		sq_try  = sq_r_q + sq_bit_q;
		e_clr   = (48'sd49152 + 48'(ratio_q) * 48'sd24) <<< (ADDR_BITS - 1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP:   if (sweep_q == '1) state_d = clr_pend_q ? ST_MAG1 : ST_IDLE;
			ST_IDLE:    if (req_acc) state_d = req.operation ? ST_RD_CTR : ST_SWEEP;
			ST_RD_CTR:  state_d = ST_LD_CTR;
			ST_LD_CTR:  state_d = ST_RD_NB;
			ST_RD_NB:   state_d = ST_LD_NB;
			ST_LD_NB:   state_d = ST_TRIG;
			ST_TRIG:    state_d = ST_TWAIT;
			ST_TWAIT: begin
				if (crsp.done) begin
					if (self_q)
						state_d = pass_q ? ST_TRIG : ST_UPDATE;
					else if (!pass_q)
						state_d = ST_TRIG;
					else
						state_d = last_nb ? ST_MUL_NEW : ST_RD_NB;
				end
			end
			ST_MUL_NEW: state_d = ST_MUL_OLD;
			ST_MUL_OLD: state_d = ST_DE;
			ST_DE:      state_d = ST_DECIDE;
			ST_DECIDE: begin
				priority if (de_q <= 25'sd0 || temp_q < 16'sd0)
					state_d = ST_TRIG;
				else if (temp_q == 16'sd0)
					state_d = ST_MAG1;
				else
					state_d = ST_DIV;
			end
			ST_DIV:     if (div_cnt_q == 6'd36) state_d = ST_MUL_B;
			ST_MUL_B:   state_d = ST_POW;
			ST_POW:     if (k_q == 5'd16) state_d = ST_FIN;
			ST_FIN:     state_d = fin_acc ? ST_TRIG : ST_MAG1;
			ST_UPDATE:  state_d = ST_MAG1;
			ST_MAG1:    state_d = ST_MAG2;
			ST_MAG2:    state_d = ST_SQRT;
			ST_SQRT:    if (sq_cnt_q == 5'd27) state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// state outputs: memory port, trig start, request stall
	always_comb begin
		req_stall  = (state_q != ST_IDLE);
		mem_we     = 1'b0;
		mem_addr   = {row_q, col_q};
		mem_wdata  = nw_q;
		creq.start = 1'b0;
		creq.phase = self_q ? base_ph : base_ph - other_q;
		unique case (state_q)
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_addr  = sweep_q;
				mem_wdata = '0;
			end
			ST_RD_NB:  mem_addr = {nb_r, nb_c};
			ST_TRIG:   creq.start = 1'b1;
			ST_UPDATE: mem_we = 1'b1;
			default: ;
		endcase
	end

	// spin memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			spin_mem[mem_addr] <= mem_wdata;
		mem_rdata <= spin_mem[mem_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			clr_pend_q  <= 1'b0;
			ratio_q     <= 16'(RATIO_RESET);
			temp_q      <= 16'(TEMP_RESET);
			cos_tot_q   <= COS_RESET;
			sin_tot_q   <= '0;
			energy_q    <= ENERGY_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_RATIO: ratio_q <= cfg_data;
					CFG_TEMP:  temp_q  <= cfg_data;
					default: ;
				endcase
			end
			// clear request and sweep
			if (state_q == ST_IDLE && req_acc && !req.operation) begin
				clr_pend_q <= 1'b1;
				sweep_q    <= '0;
				cos_tot_q  <= COS_RESET;
				sin_tot_q  <= '0;
				energy_q   <= e_clr;
			end
			if (state_q == ST_SWEEP)
				sweep_q <= sweep_q + ADDR_BITS'(1);
			if (state_q == ST_SWEEP && sweep_q == '1)
				clr_pend_q <= 1'b0;
			// totals after a kept move
			if (state_q == ST_UPDATE) begin
				cos_tot_q <= cos_tot_q + 28'(cn_q) - 28'(co_q);
				sin_tot_q <= sin_tot_q + 28'(sn_q) - 28'(so_q);
				energy_q  <= energy_q + 48'(de_q);
			end
			// output register
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			if (state_q == ST_OUT && out_free)
				rsp_valid_q <= 1'b1;
		end
	end

	// sequencer counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q    <= '0;
			pass_q <= 1'b0;
			self_q <= 1'b0;
			acc_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					self_q <= 1'b0;
					pass_q <= 1'b0;
					acc_q  <= 1'b0;
				end
				ST_LD_CTR: j_q <= '0;
				ST_LD_NB:  pass_q <= 1'b0;
				ST_TWAIT: begin
					if (crsp.done) begin
						if (self_q) begin
							pass_q <= 1'b0;
						end else if (!pass_q) begin
							pass_q <= 1'b1;
						end else begin
							j_q <= j_q + 4'd1;
						end
					end
				end
				ST_DECIDE: begin
					if (de_q <= 25'sd0 || temp_q < 16'sd0) begin
						acc_q  <= 1'b1;
						self_q <= 1'b1;
						pass_q <= 1'b1;
					end
				end
				ST_FIN: begin
					acc_q  <= fin_acc;
					self_q <= 1'b1;
					pass_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					row_q  <= SIDE_BITS'(req.site_row % SIDE);
					col_q  <= SIDE_BITS'(req.site_col % SIDE);
					step_q <= ANGLE_BITS'({req.angle_step, {ANGLE_BITS{1'b0}}} >> 16);
					draw_q <= req.uniform_draw;
				end
			end
			ST_LD_CTR: begin
				old_q     <= mem_rdata;
				nw_q      <= mem_rdata + step_q;
				nn_new_q  <= '0;
				nn_old_q  <= '0;
				nnn_new_q <= '0;
				nnn_old_q <= '0;
			end
			ST_LD_NB: other_q <= mem_rdata;
			ST_TWAIT: begin
				if (crsp.done) begin
					if (self_q) begin
						if (pass_q) begin
							co_q <= crsp.cos_val;
							so_q <= crsp.sin_val;
						end else begin
							cn_q <= crsp.cos_val;
							sn_q <= crsp.sin_val;
						end
					end else if (j_q < 4'd3) begin
						if (pass_q) nn_old_q <= nn_old_q + cos_ext;
						else        nn_new_q <= nn_new_q + cos_ext;
					end else begin
						if (pass_q) nnn_old_q <= nnn_old_q + cos_ext;
						else        nnn_new_q <= nnn_new_q + cos_ext;
					end
				end
			end
			ST_MUL_NEW: prod_new_q <= 35'(ratio_q) * 35'(nnn_new_q);
			ST_MUL_OLD: prod_old_q <= 35'(ratio_q) * 35'(nnn_old_q);
			ST_DE:      de_q <= de_w;
			ST_DECIDE: begin
				div_dq_q  <= 37'(de_q) << 12;
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				// restoring divide, one quotient bit per cycle
				div_cnt_q <= div_cnt_q + 6'd1;
				div_rem_q <= rem_ge ? 15'(rem_sh - {1'b0, temp_q[14:0]}) : rem_sh[14:0];
				div_dq_q  <= {div_dq_q[35:0], rem_ge};
			end
			ST_MUL_B: begin
				// a quotient beyond 24 bits already means probability zero
				if (div_dq_q[36:24] != '0)
					b_q <= '1;
				else
					b_q <= 27'((41'(div_dq_q[23:0]) * 41'd94548) >> 14);
				v_q <= 31'(POW_TAB[0]);
				k_q <= 5'd1;
			end
			ST_POW: begin
				if (b_q[5'd16 - k_q])
					v_q <= 31'(pow_prod >> 30);
				k_q <= k_q + 5'd1;
			end
			ST_MAG1: sq_c_q <= 56'(cos_tot_q) * 56'(cos_tot_q);
			ST_MAG2: begin
				sq_n_q   <= sq_c_q + 56'(sin_tot_q) * 56'(sin_tot_q);
				sq_r_q   <= '0;
				sq_bit_q <= 56'd1 << 54;
				sq_cnt_q <= '0;
			end
			ST_SQRT: begin
				// bit-pair square root step
				if (sq_n_q >= sq_try) begin
					sq_n_q <= sq_n_q - sq_try;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				sq_cnt_q <= sq_cnt_q + 5'd1;
			end
			ST_OUT: begin
				if (out_free) begin
					rsp_q.accepted      <= acc_q;
					rsp_q.total_energy  <= energy_q;
					rsp_q.mag_cos_sum   <= cos_tot_q;
					rsp_q.mag_sin_sum   <= sin_tot_q;
					rsp_q.mag_magnitude <= (sq_r_q[55:27] != '0) ? '1 : sq_r_q[26:0];
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hdl/xysm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XY spin Metropolis update: port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module xysm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input xysm_pkg::res_t rsp
);
	import xysm_pkg::*;

	// a held result stays presented
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	// a held result does not change
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("result changed while stalled");

	// one request in flight: the next one waits
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while busy");

	// a new result appears only as the block returns to idle
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !req_stall)
		else $error("result issued while still busy");

endmodule

bind xy_spin_metropolis_update_top xysm_checker u_xysm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

[bench/tb_xy_spin_metropolis_update_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XY spin Metropolis update: testbench
// Drives clears and trial moves with bursty requests and a stalling result
// side, writes both configuration registers between phases, and checks each
// result field against a cycle-free model of the lattice kept in the bench.
// ----------------------------------------------------------------------------
module tb_xy_spin_metropolis_update_top;
	import xysm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	res_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	xy_spin_metropolis_update_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam logic REQ_CLEAR = 1'b0;
	localparam logic REQ_TRIAL = 1'b1;

	// lattice model state
	logic [15:0] lat_angle [NSITES];
	longint      lat_ratio, lat_temp;
	longint      lat_cos, lat_sin, lat_energy;
	longint      unsigned half_pow [17];

	res_t   pending_results [$];
	int     errors;
	int     burst_left;
	int     stall_mode;
	logic   sent_any;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint wrap_w(longint v, int w);
		longint m;
		m = v & ((64'sd1 <<< w) - 1);
		if (m[w-1])
			m = m - (64'sd1 <<< w);
		return m;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint clamp_one(longint v);
		if (v > ONE_Q14) return ONE_Q14;
		if (v < -ONE_Q14) return -ONE_Q14;
		return v;
	endfunction

	// CORDIC cos/sin of a phase, Q.14
	function automatic void phase_trig(input logic [15:0] ph, output longint c,
		output longint s);
		longint x, y, z, dx, dy;
		logic [31:0] u;
		logic flip;
		u = {ph, 16'd0};
		z = longint'($signed(u));
		x = 652032874;
		y = 0;
		flip = 1'b0;
		if (z > (64'sd1 <<< 30)) begin
			z = z - (64'sd1 <<< 31);
			flip = 1'b1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z = z + (64'sd1 <<< 31);
			flip = 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - longint'(ROT_TAB[i]);
			end else begin
				x = x + dx; y = y - dy; z = z + longint'(ROT_TAB[i]);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clamp_one((x + 32768) >>> 16);
		s = clamp_one((y + 32768) >>> 16);
	endfunction

	function automatic longint bond_cos(logic [15:0] ctr, int r, int c);
		longint cv, sv;
		phase_trig(ctr - lat_angle[(r % SIDE) * SIDE + (c % SIDE)], cv, sv);
		return cv;
	endfunction

	function automatic longint site_energy(int r, int c, logic [15:0] ctr);
		int sc;
		longint nn, nnn;
		sc = ((r & 1) == (c & 1)) ? c + SIDE - 1 : c + 1;
		nn = bond_cos(ctr, r, sc) + bond_cos(ctr, r + 1, c) + bond_cos(ctr, r + SIDE - 1, c);
		nnn = bond_cos(ctr, r + 1, c + SIDE - 1) + bond_cos(ctr, r + 1, c + 1)
			+ bond_cos(ctr, r + SIDE - 1, c + 1) + bond_cos(ctr, r + SIDE - 1, c + SIDE - 1)
			+ bond_cos(ctr, r + 2, c) + bond_cos(ctr, r + 2 * SIDE - 2, c);
		return nn + ((lat_ratio * nnn + 2048) >>> 12);
	endfunction

	function automatic logic move_kept(longint de, longint unsigned draw);
		longint unsigned na, b, n, f, v, p;
		if (de <= 0) return 1'b1;
		if (lat_temp < 0) return 1'b1;
		if (lat_temp == 0) return 1'b0;
		na = (longint'(de) * 4096) / longint'(lat_temp);
		b = (na * 94548) >> 14;
		n = b >> 16;
		f = b & 16'hFFFF;
		if (n > 16) return 1'b0;
		v = 64'd1 << 30;
		for (int k = 1; k <= 16; k++)
			if ((f >> (16 - k)) & 1)
				v = (v * half_pow[k] + (64'd1 << 29)) >> 30;
		v = v >> n;
		p = (v + (64'd1 << 13)) >> 14;
		return draw < p;
	endfunction

	function automatic void clear_lattice();
		for (int i = 0; i < NSITES; i++)
			lat_angle[i] = '0;
		lat_cos = wrap_w(longint'(NSITES) * ONE_Q14, 28);
		lat_sin = 0;
		lat_energy = wrap_w((3 * ONE_Q14 + 24 * lat_ratio) * longint'(NSITES) / 2, 48);
	endfunction

	// apply one request to the model and return the result it must produce
	function automatic res_t metropolis_step(req_t q);
		res_t o;
		logic kept;
		logic [15:0] old_a, new_a;
		longint de, co, so, cn, sn;
		longint unsigned mag;
		int idx;
		kept = 1'b0;
		if (q.operation == REQ_CLEAR) begin
			clear_lattice();
		end else begin
			idx = q.site_row * SIDE + q.site_col;
			old_a = lat_angle[idx];
			new_a = old_a + q.angle_step;
			de = site_energy(q.site_row, q.site_col, new_a)
				- site_energy(q.site_row, q.site_col, old_a);
			kept = move_kept(de, q.uniform_draw);
			if (kept) begin
				phase_trig(old_a, co, so);
				phase_trig(new_a, cn, sn);
				lat_angle[idx] = new_a;
				lat_cos = wrap_w(lat_cos + cn - co, 28);
				lat_sin = wrap_w(lat_sin + sn - so, 28);
				lat_energy = wrap_w(lat_energy + de, 48);
			end
		end
		mag = int_sqrt(longint'(lat_cos * lat_cos) + longint'(lat_sin * lat_sin));
		if (mag > 134217727) mag = 134217727;
		o.accepted = kept;
		o.total_energy = lat_energy[47:0];
		o.mag_cos_sum = lat_cos[27:0];
		o.mag_sin_sum = lat_sin[27:0];
		o.mag_magnitude = mag[26:0];
		return o;
	endfunction

	// send one request; valid stays high across a burst
	task automatic send_req(req_t q);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		req <= q;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(metropolis_step(q));
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_RATIO) lat_ratio = longint'($signed(val));
		else if (idx == CFG_TEMP) lat_temp = longint'($signed(val));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drain results, then reprogram both registers
	task automatic set_phase(logic [15:0] ratio, logic [15:0] temp);
		if (req_valid) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		burst_left = 0;
		wait (pending_results.size() == 0);
		repeat (600) @(negedge clk);
		write_reg(CFG_RATIO, ratio);
		write_reg(CFG_TEMP, temp);
	endtask

	function automatic req_t trial(int r, int c, int st, int u);
		req_t q;
		q.operation = REQ_TRIAL;
		q.site_row = 6'(r);
		q.site_col = 6'(c);
		q.angle_step = 16'(st);
		q.uniform_draw = 16'(u);
		return q;
	endfunction

	function automatic req_t rand_req();
		req_t q;
		q = trial($urandom_range(0, 63), $urandom_range(0, 63), $urandom, $urandom);
		// small rotations give dE near zero so the draw matters
		if ($urandom_range(0, 2) == 0)
			q.angle_step = 16'(int'($urandom_range(0, 2048)) - 1024);
		return q;
	endfunction

	// directed: field extremes, clear, and the temperature special cases
	task automatic test_directed();
		req_t q;
		q = '0;
		q.operation = REQ_CLEAR;
		send_req(q);
		send_req(trial(0, 0, 16'h4000, 16'hFFFF));
		send_req(trial(63, 63, 16'hFFFF, 16'h0000));
		send_req(trial(0, 63, 16'h8000, 16'h0000));
		send_req(trial(63, 0, 16'h0001, 16'hFFFF));
		send_req(trial(1, 2, 16'h2000, 16'h8000));
		send_req(trial(0, 0, 16'hC000, 16'h0001));
		send_req(trial(0, 0, 16'h0000, 16'hFFFF));
		send_req(q);
		set_phase(16'h0000, 16'h0000);
		send_req(trial(10, 10, 16'h8000, 16'h0000));
		send_req(trial(11, 10, 16'h0100, 16'h0000));
		set_phase(16'h7FFF, 16'hF000);
		send_req(trial(5, 6, 16'h8000, 16'hFFFF));
		send_req(trial(6, 6, 16'h7000, 16'hFFFF));
		send_req(q);
		set_phase(16'h8000, 16'h0001);
		send_req(trial(20, 30, 16'h0040, 16'h0000));
		send_req(trial(21, 30, 16'h8000, 16'h0000));
		set_phase(16'h8000, 16'h7FFF);
		send_req(trial(20, 30, 16'h4000, 16'h0000));
		send_req(q);
		send_req(trial(2, 3, 16'h4000, 16'hFFFF));
		set_phase(16'h0000, 16'h8000);
		// unknown register indexes leave both registers alone
		write_reg(2'd2, 16'h1234);
		write_reg(2'd3, 16'hFFFF);
		send_req(trial(2, 4, 16'h9000, 16'hFFFF));
	endtask

	task automatic test_random(logic [15:0] ratio, logic [15:0] temp, int count);
		req_t q;
		set_phase(ratio, temp);
		for (int i = 0; i < count; i++) begin
			q = rand_req();
			// rare clears: each one costs a full memory sweep
			if ($urandom_range(0, 199) == 0) q.operation = REQ_CLEAR;
			send_req(q);
		end
	endtask

	// result side stall pattern, changing mode now and then
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 1) == 0);
				default: rsp_stall <= ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, rsp);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (rsp.accepted !== e.accepted) begin
					$display("%0t: accepted exp %0d got %0d", $time, e.accepted, rsp.accepted);
					errors++;
				end
				if (rsp.total_energy !== e.total_energy) begin
					$display("%0t: total_energy exp %0d got %0d", $time,
						e.total_energy, rsp.total_energy);
					errors++;
				end
				if (rsp.mag_cos_sum !== e.mag_cos_sum) begin
					$display("%0t: mag_cos_sum exp %0d got %0d", $time,
						e.mag_cos_sum, rsp.mag_cos_sum);
					errors++;
				end
				if (rsp.mag_sin_sum !== e.mag_sin_sum) begin
					$display("%0t: mag_sin_sum exp %0d got %0d", $time,
						e.mag_sin_sum, rsp.mag_sin_sum);
					errors++;
				end
				if (rsp.mag_magnitude !== e.mag_magnitude) begin
					$display("%0t: mag_magnitude exp %0d got %0d", $time,
						e.mag_magnitude, rsp.mag_magnitude);
					errors++;
				end
			end
		end
	end

	initial begin
		#200_000_000;
		$display("xy_spin_metropolis_update_top: mismatch");
		$finish;
	end

	initial begin
		errors = 0;
		burst_left = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		lat_ratio = RATIO_RESET;
		lat_temp = TEMP_RESET;
		half_pow[0] = 64'd1 << 30;
		half_pow[1] = int_sqrt(64'd1 << 59);
		for (int k = 2; k <= 16; k++)
			half_pow[k] = int_sqrt(half_pow[k-1] << 30);
		clear_lattice();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(16'd410, 16'd4096, 500);
		test_random(16'hF800, 16'd800, 400);
		test_random(16'd4096, 16'd20000, 300);
		test_random(16'h7FFF, 16'd100, 250);
		test_random(16'h8000, 16'hE000, 150);

		req_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (600) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("xy_spin_metropolis_update_top: match");
		else
			$display("xy_spin_metropolis_update_top: mismatch");
		$finish;
	end

endmodule
